@@ rtl/core/dtdq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtdq_pkg
// Types, codes and shared constants of the deadline task dispatch queue.
// ----------------------------------------------------------------------------
package dtdq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int TIME_W    = 63;
  localparam int HANDLE_W  = 8;
  localparam int COUNT_W   = 6;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [1:0] OPC_ENQ    = 2'd0;
  localparam logic [1:0] OPC_TICK   = 2'd1;
  localparam logic [1:0] OPC_RESP   = 2'd2;
  localparam logic [1:0] OPC_UNUSED = 2'd3;

  localparam logic [1:0] RESP_DONE       = 2'd0;
  localparam logic [1:0] RESP_RETRY      = 2'd1;
  localparam logic [1:0] RESP_STOP       = 2'd2;
  localparam logic [1:0] RESP_RETRY_STOP = 2'd3;

  localparam logic [1:0] KIND_ACK      = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_FULL     = 2'd2;
  localparam logic [1:0] KIND_ERR      = 2'd3;

  localparam logic [CFG_AW-3:0] CFG_REG_SORT = 1'b0;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [HANDLE_W-1:0] task_handle;
    logic [TIME_W-1:0]   deadline;
    logic [TIME_W-1:0]   now_time;
    logic [1:0]          response_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [HANDLE_W-1:0] dispatch_handle;
    logic [TIME_W-1:0]   dispatch_start;
    logic [COUNT_W-1:0]  waiting_count;
    logic [COUNT_W-1:0]  sleeping_count;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [TIME_W-1:0]   start;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LATCH,
    DP_RES_ACK,
    DP_RES_FULL,
    DP_RES_ERR,
    DP_PUSH_IN,
    DP_TICK_CLR,
    DP_TICK_POP,
    DP_DISP_RD,
    DP_DISP_LOAD,
    DP_RESP,
    DP_FIN_INIT,
    DP_FIN_RUN_RD,
    DP_PUSH_RUN,
    DP_FIN_RTY_RD,
    DP_PUSH_RTY,
    DP_SORT_INIT,
    DP_SORT_KEY,
    DP_SORT_SHIFT,
    DP_SORT_PUT,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK_CMP,
    ST_TICK_END,
    ST_DISP_RD,
    ST_DISP_LOAD,
    ST_FIN_INIT,
    ST_FIN_RUN,
    ST_FIN_RUN_WR,
    ST_FIN_RTY,
    ST_FIN_RTY_WR,
    ST_SORT_INIT,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       stop;
    logic       full;
    logic       busy;
    logic       sort_en;
    logic       store_empty;
    logic       store_one;
    logic       store_gt1;
    logic       expired;
    logic       run_zero;
    logic       retry_zero;
    logic       any_back;
    logic       shift;
    logic       j_gt1;
    logic       i_last;
    logic       out_free;
  } dp_status_t;

endpackage

@@ rtl/core/dtdq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/dtdq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtdq_datapath
// Task store, run and retry lists, counters, sort indexes and result register.
// ----------------------------------------------------------------------------
module dtdq_datapath #(
  parameter int DEPTH = dtdq_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtdq_pkg::dp_op_t     op,
  input  dtdq_pkg::in_item_t   in_data,
  input  logic                 sort_en,
  input  logic                 out_stall,
  output logic                 out_valid,
  output dtdq_pkg::out_item_t  out_data,
  output dtdq_pkg::dp_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dtdq_pkg::in_item_t  in_r, in_nxt;
  dtdq_pkg::entry_t    cur_r, cur_nxt;
  dtdq_pkg::entry_t    key_r, key_nxt;
  dtdq_pkg::out_item_t out_r, out_nxt;
  logic [CW-1:0] store_cnt_r, store_cnt_nxt;
  logic [CW-1:0] run_cnt_r, run_cnt_nxt;
  logic [CW-1:0] retry_cnt_r, retry_cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] res_wait_r, res_wait_nxt;
  logic [1:0]    res_kind_r, res_kind_nxt;
  logic [dtdq_pkg::HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [dtdq_pkg::TIME_W-1:0]   res_start_r, res_start_nxt;
  logic busy_r, busy_nxt;
  logic any_r, any_nxt;
  logic out_valid_r, out_valid_nxt;

  logic st_we, st_re, run_we, run_re, rt_we, rt_re;
  logic [AW-1:0] st_waddr, st_raddr, run_waddr, run_raddr, rt_waddr, rt_raddr;
  dtdq_pkg::entry_t st_wdata, run_wdata, rt_wdata;
  logic [dtdq_pkg::ENTRY_W-1:0] st_rbits, run_rbits, rt_rbits;
  dtdq_pkg::entry_t st_rdata, run_rdata, rt_rdata;
  logic [CW+1:0] held;
  logic retry_req;

  assign st_rdata  = dtdq_pkg::entry_t'(st_rbits);
  assign run_rdata = dtdq_pkg::entry_t'(run_rbits);
  assign rt_rdata  = dtdq_pkg::entry_t'(rt_rbits);

  dtdq_ram #(.WIDTH(dtdq_pkg::ENTRY_W), .DEPTH(DEPTH)) u_store_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rbits)
  );

  dtdq_ram #(.WIDTH(dtdq_pkg::ENTRY_W), .DEPTH(DEPTH)) u_run_ram (
    .clk(clk), .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
    .re(run_re), .raddr(run_raddr), .rdata(run_rbits)
  );

  dtdq_ram #(.WIDTH(dtdq_pkg::ENTRY_W), .DEPTH(DEPTH)) u_retry_ram (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .re(rt_re), .raddr(rt_raddr), .rdata(rt_rbits)
  );

  assign retry_req = (in_r.response_code == dtdq_pkg::RESP_RETRY) ||
                     (in_r.response_code == dtdq_pkg::RESP_RETRY_STOP);
  assign held = (CW+2)'(store_cnt_r) + (CW+2)'(run_cnt_r) + (CW+2)'(retry_cnt_r) +
                (CW+2)'(busy_r);

  always_comb begin
    in_nxt         = in_r;
    cur_nxt        = cur_r;
    key_nxt        = key_r;
    out_nxt        = out_r;
    store_cnt_nxt  = store_cnt_r;
    run_cnt_nxt    = run_cnt_r;
    retry_cnt_nxt  = retry_cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    res_wait_nxt   = res_wait_r;
    res_kind_nxt   = res_kind_r;
    res_handle_nxt = res_handle_r;
    res_start_nxt  = res_start_r;
    busy_nxt       = busy_r;
    any_nxt        = any_r;
    out_valid_nxt  = out_valid_r && out_stall;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_waddr  = AW'(store_cnt_r);
    st_raddr  = AW'(store_cnt_r - 1'b1);
    st_wdata  = st_rdata;
    run_we    = 1'b0;
    run_re    = 1'b0;
    run_waddr = AW'(run_cnt_r);
    run_raddr = AW'(run_cnt_r - 1'b1);
    run_wdata = st_rdata;
    rt_we     = 1'b0;
    rt_re     = 1'b0;
    rt_waddr  = AW'(retry_cnt_r);
    rt_raddr  = AW'(retry_cnt_r - 1'b1);
    rt_wdata  = cur_r;
    unique case (op)
      dtdq_pkg::DP_NONE: begin
      end
      dtdq_pkg::DP_LATCH: begin
        in_nxt = in_data;
      end
      dtdq_pkg::DP_RES_ACK, dtdq_pkg::DP_RES_FULL, dtdq_pkg::DP_RES_ERR: begin
        res_kind_nxt   = (op == dtdq_pkg::DP_RES_ACK)  ? dtdq_pkg::KIND_ACK :
                         (op == dtdq_pkg::DP_RES_FULL) ? dtdq_pkg::KIND_FULL :
                                                         dtdq_pkg::KIND_ERR;
        res_handle_nxt = '0;
        res_start_nxt  = '0;
        res_wait_nxt   = run_cnt_r;
      end
      dtdq_pkg::DP_PUSH_IN: begin
        st_we          = 1'b1;
        st_wdata       = '{deadline: in_r.deadline, start: in_r.now_time,
                           handle: in_r.task_handle};
        store_cnt_nxt  = store_cnt_r + 1'b1;
        res_kind_nxt   = dtdq_pkg::KIND_ACK;
        res_handle_nxt = '0;
        res_start_nxt  = '0;
        res_wait_nxt   = run_cnt_r;
      end
      dtdq_pkg::DP_TICK_CLR: begin
        run_cnt_nxt   = '0;
        retry_cnt_nxt = '0;
        st_re         = 1'b1;
      end
      dtdq_pkg::DP_TICK_POP: begin
        run_we        = 1'b1;
        run_cnt_nxt   = run_cnt_r + 1'b1;
        store_cnt_nxt = store_cnt_r - 1'b1;
        st_re         = 1'b1;
        st_raddr      = AW'(store_cnt_r - CW'(2));
      end
      dtdq_pkg::DP_DISP_RD, dtdq_pkg::DP_FIN_RUN_RD: begin
        run_re      = 1'b1;
        run_cnt_nxt = run_cnt_r - 1'b1;
      end
      dtdq_pkg::DP_DISP_LOAD: begin
        cur_nxt        = run_rdata;
        busy_nxt       = 1'b1;
        res_kind_nxt   = dtdq_pkg::KIND_DISPATCH;
        res_handle_nxt = run_rdata.handle;
        res_start_nxt  = run_rdata.start;
        res_wait_nxt   = run_cnt_r;
      end
      dtdq_pkg::DP_RESP: begin
        if (retry_req && (retry_cnt_r < CW'(DEPTH))) begin
          rt_we         = 1'b1;
          retry_cnt_nxt = retry_cnt_r + 1'b1;
        end
        busy_nxt = 1'b0;
      end
      dtdq_pkg::DP_FIN_INIT: begin
        res_kind_nxt   = dtdq_pkg::KIND_ACK;
        res_handle_nxt = '0;
        res_start_nxt  = '0;
        res_wait_nxt   = run_cnt_r;
        any_nxt        = (run_cnt_r != '0) || (retry_cnt_r != '0);
      end
      dtdq_pkg::DP_PUSH_RUN: begin
        if (store_cnt_r < CW'(DEPTH)) begin
          st_we         = 1'b1;
          st_wdata      = run_rdata;
          store_cnt_nxt = store_cnt_r + 1'b1;
        end
      end
      dtdq_pkg::DP_FIN_RTY_RD: begin
        rt_re         = 1'b1;
        retry_cnt_nxt = retry_cnt_r - 1'b1;
      end
      dtdq_pkg::DP_PUSH_RTY: begin
        if (store_cnt_r < CW'(DEPTH)) begin
          st_we         = 1'b1;
          st_wdata      = rt_rdata;
          store_cnt_nxt = store_cnt_r + 1'b1;
        end
      end
      dtdq_pkg::DP_SORT_INIT: begin
        i_nxt    = CW'(1);
        st_re    = 1'b1;
        st_raddr = AW'(CW'(1));
      end
      dtdq_pkg::DP_SORT_KEY: begin
        key_nxt  = st_rdata;
        j_nxt    = i_r;
        st_re    = 1'b1;
        st_raddr = AW'(i_r - 1'b1);
      end
      dtdq_pkg::DP_SORT_SHIFT: begin
        st_we    = 1'b1;
        st_waddr = AW'(j_r);
        st_wdata = st_rdata;
        j_nxt    = j_r - 1'b1;
        st_re    = 1'b1;
        st_raddr = AW'(j_r - CW'(2));
      end
      dtdq_pkg::DP_SORT_PUT: begin
        st_we    = 1'b1;
        st_waddr = AW'(j_r);
        st_wdata = key_r;
        i_nxt    = i_r + 1'b1;
        st_re    = 1'b1;
        st_raddr = AW'(i_r + 1'b1);
      end
      dtdq_pkg::DP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_nxt = '{result_kind: res_kind_r, dispatch_handle: res_handle_r,
                    dispatch_start: res_start_r,
                    waiting_count: dtdq_pkg::COUNT_W'(res_wait_r),
                    sleeping_count: dtdq_pkg::COUNT_W'(store_cnt_r)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_cnt_r <= '0;
      run_cnt_r   <= '0;
      retry_cnt_r <= '0;
      busy_r      <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
    end else begin
      store_cnt_r <= store_cnt_nxt;
      run_cnt_r   <= run_cnt_nxt;
      retry_cnt_r <= retry_cnt_nxt;
      busy_r      <= busy_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r         <= in_nxt;
    key_r        <= key_nxt;
    out_r        <= out_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    res_wait_r   <= res_wait_nxt;
    res_kind_r   <= res_kind_nxt;
    res_handle_r <= res_handle_nxt;
    res_start_r  <= res_start_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    status.opcode      = in_r.opcode;
    status.stop        = (in_r.response_code == dtdq_pkg::RESP_STOP) ||
                         (in_r.response_code == dtdq_pkg::RESP_RETRY_STOP);
    status.full        = held >= (CW+2)'(DEPTH);
    status.busy        = busy_r;
    status.sort_en     = sort_en;
    status.store_empty = store_cnt_r == '0;
    status.store_one   = store_cnt_r == CW'(1);
    status.store_gt1   = store_cnt_r > CW'(1);
    status.expired     = st_rdata.deadline < in_r.now_time;
    status.run_zero    = run_cnt_r == '0;
    status.retry_zero  = retry_cnt_r == '0;
    status.any_back    = any_r;
    status.shift       = st_rdata.deadline < key_r.deadline;
    status.j_gt1       = j_r > CW'(1);
    status.i_last      = CW'(i_r + 1'b1) >= store_cnt_r;
    status.out_free    = !out_valid_r || !out_stall;
  end

endmodule

@@ rtl/core/dtdq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtdq_ctrl
// Sequencer: decodes each item and steps the datapath through its operation.
// ----------------------------------------------------------------------------
module dtdq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dtdq_pkg::dp_status_t status,
  output dtdq_pkg::dp_op_t     op
);

  dtdq_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = dtdq_pkg::DP_NONE;
    in_stall  = 1'b1;
    unique case (state_r)
      dtdq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op        = dtdq_pkg::DP_LATCH;
          state_nxt = dtdq_pkg::ST_DECODE;
        end
      end
      dtdq_pkg::ST_DECODE: begin
        priority if (status.opcode == dtdq_pkg::OPC_ENQ) begin
          if (status.full) begin
            op        = dtdq_pkg::DP_RES_FULL;
            state_nxt = dtdq_pkg::ST_EMIT;
          end else begin
            op        = dtdq_pkg::DP_PUSH_IN;
            state_nxt = status.sort_en ? dtdq_pkg::ST_SORT_INIT : dtdq_pkg::ST_EMIT;
          end
        end else if (status.opcode == dtdq_pkg::OPC_TICK) begin
          if (status.busy) begin
            op        = dtdq_pkg::DP_RES_ERR;
            state_nxt = dtdq_pkg::ST_EMIT;
          end else begin
            op        = dtdq_pkg::DP_TICK_CLR;
            state_nxt = status.store_empty ? dtdq_pkg::ST_TICK_END : dtdq_pkg::ST_TICK_CMP;
          end
        end else if (status.opcode == dtdq_pkg::OPC_RESP) begin
          if (!status.busy) begin
            op        = dtdq_pkg::DP_RES_ERR;
            state_nxt = dtdq_pkg::ST_EMIT;
          end else begin
            op        = dtdq_pkg::DP_RESP;
            state_nxt = (!status.stop && !status.run_zero) ? dtdq_pkg::ST_DISP_RD :
                                                             dtdq_pkg::ST_FIN_INIT;
          end
        end else begin
          op        = dtdq_pkg::DP_RES_ERR;
          state_nxt = dtdq_pkg::ST_EMIT;
        end
      end
      dtdq_pkg::ST_TICK_CMP: begin
        if (status.expired) begin
          op        = dtdq_pkg::DP_TICK_POP;
          state_nxt = status.store_one ? dtdq_pkg::ST_TICK_END : dtdq_pkg::ST_TICK_CMP;
        end else begin
          state_nxt = dtdq_pkg::ST_TICK_END;
        end
      end
      dtdq_pkg::ST_TICK_END: begin
        if (status.run_zero) begin
          op        = dtdq_pkg::DP_RES_ACK;
          state_nxt = dtdq_pkg::ST_EMIT;
        end else begin
          op        = dtdq_pkg::DP_DISP_RD;
          state_nxt = dtdq_pkg::ST_DISP_LOAD;
        end
      end
      dtdq_pkg::ST_DISP_RD: begin
        op        = dtdq_pkg::DP_DISP_RD;
        state_nxt = dtdq_pkg::ST_DISP_LOAD;
      end
      dtdq_pkg::ST_DISP_LOAD: begin
        op        = dtdq_pkg::DP_DISP_LOAD;
        state_nxt = dtdq_pkg::ST_EMIT;
      end
      dtdq_pkg::ST_FIN_INIT: begin
        op        = dtdq_pkg::DP_FIN_INIT;
        state_nxt = dtdq_pkg::ST_FIN_RUN;
      end
      dtdq_pkg::ST_FIN_RUN: begin
        if (!status.run_zero) begin
          op        = dtdq_pkg::DP_FIN_RUN_RD;
          state_nxt = dtdq_pkg::ST_FIN_RUN_WR;
        end else begin
          state_nxt = dtdq_pkg::ST_FIN_RTY;
        end
      end
      dtdq_pkg::ST_FIN_RUN_WR: begin
        op        = dtdq_pkg::DP_PUSH_RUN;
        state_nxt = dtdq_pkg::ST_FIN_RUN;
      end
      dtdq_pkg::ST_FIN_RTY: begin
        if (!status.retry_zero) begin
          op        = dtdq_pkg::DP_FIN_RTY_RD;
          state_nxt = dtdq_pkg::ST_FIN_RTY_WR;
        end else begin
          state_nxt = (status.any_back && status.sort_en) ? dtdq_pkg::ST_SORT_INIT :
                                                            dtdq_pkg::ST_EMIT;
        end
      end
      dtdq_pkg::ST_FIN_RTY_WR: begin
        op        = dtdq_pkg::DP_PUSH_RTY;
        state_nxt = dtdq_pkg::ST_FIN_RTY;
      end
      dtdq_pkg::ST_SORT_INIT: begin
        op        = dtdq_pkg::DP_SORT_INIT;
        state_nxt = status.store_gt1 ? dtdq_pkg::ST_SORT_KEY : dtdq_pkg::ST_EMIT;
      end
      dtdq_pkg::ST_SORT_KEY: begin
        op        = dtdq_pkg::DP_SORT_KEY;
        state_nxt = dtdq_pkg::ST_SORT_CMP;
      end
      dtdq_pkg::ST_SORT_CMP: begin
        if (status.shift) begin
          op        = dtdq_pkg::DP_SORT_SHIFT;
          state_nxt = status.j_gt1 ? dtdq_pkg::ST_SORT_CMP : dtdq_pkg::ST_SORT_PUT;
        end else begin
          state_nxt = dtdq_pkg::ST_SORT_PUT;
        end
      end
      dtdq_pkg::ST_SORT_PUT: begin
        op        = dtdq_pkg::DP_SORT_PUT;
        state_nxt = status.i_last ? dtdq_pkg::ST_EMIT : dtdq_pkg::ST_SORT_KEY;
      end
      dtdq_pkg::ST_EMIT: begin
        if (status.out_free) begin
          op        = dtdq_pkg::DP_EMIT;
          state_nxt = dtdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dtdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/deadline_task_dispatch_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_task_dispatch_queue_top
// Deadline-sorted task store with tick-driven dispatch and response handling.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid / in_stall  in_item_t
//   out_*        output     out_valid/out_stall  out_item_t
//   cfg_*        input      APB write/read       sort_enabled at byte 0
//
// One item at a time: the input stalls until the item's result is emitted.
// Enqueue, error or full store: decode, then emit; an enqueue adds the
// insertion sort when sorting is on. Tick: expired tasks move from the store
// to the run list and one is dispatched if any expired. Response: the next
// run task is dispatched, or on stop or an empty run list the run and retry
// tasks are put back, plus the sort.
// One read and one write a cycle on the store RAM pace the sort.
// Reset is synchronous; the RAMs are not cleared. The result register frees
// the input side while a result is stalled; out_stall only holds the emit.
// ----------------------------------------------------------------------------
module deadline_task_dispatch_queue_top #(
  parameter int DEPTH = dtdq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dtdq_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dtdq_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dtdq_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [dtdq_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [dtdq_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic sort_en_r, sort_en_nxt;
  logic cfg_hit;
  dtdq_pkg::dp_op_t     op;
  dtdq_pkg::dp_status_t status;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[dtdq_pkg::CFG_AW-1:2] == dtdq_pkg::CFG_REG_SORT;
  assign cfg_prdata = cfg_hit ? {{(dtdq_pkg::CFG_DW-1){1'b0}}, sort_en_r} : '0;

  always_comb begin
    sort_en_nxt = sort_en_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      sort_en_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_en_r <= 1'b1;
    end else begin
      sort_en_r <= sort_en_nxt;
    end
  end

  dtdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  dtdq_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .sort_en   (sort_en_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

endmodule
